// ===== src/mpa_pkg.sv =====
// ----------------------------------------------------------------------------
// mpa_pkg
// shared types, constants and helpers for the max pooling with argmax block
// ----------------------------------------------------------------------------
package mpa_pkg;

    localparam int MAX_DIM      = 64;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_KERNEL   = 4;
    localparam int SLOT_COLS    = MAX_DIM + MAX_KERNEL;
    localparam int SLOT_COUNT   = MAX_KERNEL * SLOT_COLS;
    localparam int SLOT_AW      = $clog2(SLOT_COUNT);
    localparam int GEN_W        = 4;

    localparam logic [2:0] CFG_KERNEL   = 3'd0;
    localparam logic [2:0] CFG_STRIDE   = 3'd1;
    localparam logic [2:0] CFG_PAD      = 3'd2;
    localparam logic [2:0] CFG_HEIGHT   = 3'd3;
    localparam logic [2:0] CFG_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_CHANNELS = 3'd5;

    typedef struct packed {
        logic [2:0] k;
        logic [2:0] s;
        logic [1:0] p;
        logic [6:0] hh;
        logic [6:0] ww;
        logic [6:0] cc;
    } cfg_t;

    typedef struct packed {
        logic       any;
        logic [1:0] first;
        logic [1:0] last;
        logic [1:0] lastdone;
        logic [3:0] done;
        logic [6:0] q;
    } span_t;

    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             seen;
        logic [17:0]      index;
        logic [15:0]      max;
    } slot_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_SETUP,
        ST_RD,
        ST_WR
    } state_t;

    // ceil(256 / s), one correction step brings the quotient exact
    function automatic logic [8:0] recip(input logic [2:0] s);
        logic [8:0] r;
        case (s)
            3'd2:    r = 9'd128;
            3'd3:    r = 9'd86;
            3'd4:    r = 9'd64;
            3'd5:    r = 9'd52;
            3'd6:    r = 9'd43;
            3'd7:    r = 9'd37;
            default: r = 9'd256;
        endcase
        return r;
    endfunction

endpackage

// ===== src/mpa_ram.sv =====
// ----------------------------------------------------------------------------
// mpa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/mpa_cfg.sv =====
// ----------------------------------------------------------------------------
// mpa_cfg
// configuration registers and their saturated working values
// ----------------------------------------------------------------------------
module mpa_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [6:0]    cfg_data,
    output mpa_pkg::cfg_t cfg
);
    import mpa_pkg::*;

    logic [2:0] kernel_reg;
    logic [2:0] stride_reg;
    logic [1:0] pad_reg;
    logic [6:0] height_reg;
    logic [6:0] width_reg;
    logic [6:0] chan_reg;
    logic [2:0] k_eff;
    logic [1:0] p_lim;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= 3'd2;
            stride_reg <= 3'd2;
            pad_reg    <= 2'd0;
            height_reg <= 7'd64;
            width_reg  <= 7'd64;
            chan_reg   <= 7'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_KERNEL:   kernel_reg <= cfg_data[2:0];
                CFG_STRIDE:   stride_reg <= cfg_data[2:0];
                CFG_PAD:      pad_reg    <= cfg_data[1:0];
                CFG_HEIGHT:   height_reg <= cfg_data;
                CFG_WIDTH:    width_reg  <= cfg_data;
                CFG_CHANNELS: chan_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    function automatic logic [6:0] clamp_dim(input logic [6:0] v, input logic [6:0] hi);
        logic [6:0] r;
        if (v == 7'd0)
        begin
            r = 7'd1;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    always_comb
    begin
        if (kernel_reg == 3'd0)
        begin
            k_eff = 3'd1;
        end
        else if (kernel_reg > 3'(MAX_KERNEL))
        begin
            k_eff = 3'(MAX_KERNEL);
        end
        else
        begin
            k_eff = kernel_reg;
        end
        p_lim  = (k_eff > 3'd2) ? 2'd2 : 2'(k_eff - 3'd1);
        cfg.k  = k_eff;
        cfg.s  = (stride_reg == 3'd0) ? 3'd1 : stride_reg;
        cfg.p  = (pad_reg > p_lim) ? p_lim : pad_reg;
        cfg.hh = clamp_dim(height_reg, 7'(MAX_DIM));
        cfg.ww = clamp_dim(width_reg, 7'(MAX_DIM));
        cfg.cc = clamp_dim(chan_reg, 7'(MAX_CHANNELS));
    end

endmodule

// ===== src/mpa_span.sv =====
// ----------------------------------------------------------------------------
// mpa_span
// per-axis window range: which window origins cover a position and which
// of them end there, via reciprocal division by the stride
// ----------------------------------------------------------------------------
module mpa_span (
    input  logic           clk,
    input  logic           start,
    input  logic [5:0]     pos,
    input  logic [6:0]     dim,
    input  mpa_pkg::cfg_t  cfg,
    output mpa_pkg::span_t span
);
    import mpa_pkg::*;

    logic [5:0]  pos_reg;
    logic [6:0]  x_reg;
    logic [15:0] prod_reg;
    logic [6:0]  q_reg;
    logic [6:0]  x_in;
    logic [7:0]  q0;
    logic [10:0] qs;
    logic [7:0]  q_fix;
    span_t       span_next;
    logic [3:0]  valid;
    logic [3:0]  done;

    assign x_in = 7'(pos) + 7'(cfg.p);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            pos_reg  <= pos;
            x_reg    <= x_in;
            prod_reg <= 16'(x_in) * 16'(recip(cfg.s));
        end
        q_reg <= q_fix[6:0];
        span  <= span_next;
    end

    always_comb
    begin
        q0    = prod_reg[15:8];
        qs    = 11'(q0) * 11'(cfg.s);
        q_fix = (qs > 11'(x_reg)) ? q0 - 8'd1 : q0;
    end

    always_comb
    begin
        logic [6:0]  i;
        logic [10:0] is;
        logic [10:0] wend;
        for (int a = 0; a < 4; a++)
        begin
            i        = q_reg - 7'(a);
            is       = 11'(i) * 11'(cfg.s);
            wend     = is + 11'(cfg.k);
            valid[a] = (q_reg >= 7'(a)) && (wend - 11'd1 >= 11'(x_reg))
                       && (wend <= 11'(dim) + 11'({cfg.p, 1'b0}));
            done[a]  = (wend - 11'd1 == 11'(x_reg))
                       || ((wend >= 11'(dim) + 11'(cfg.p)) && (7'(pos_reg) == dim - 7'd1));
        end
        span_next.first    = 2'd0;
        span_next.last     = 2'd0;
        span_next.lastdone = 2'd0;
        for (int a = 0; a < 4; a++)
        begin
            if (valid[a])
            begin
                span_next.first = 2'(a);
            end
        end
        for (int a = 3; a >= 0; a--)
        begin
            if (valid[a])
            begin
                span_next.last = 2'(a);
            end
            if (valid[a] && done[a])
            begin
                span_next.lastdone = 2'(a);
            end
        end
        span_next.any  = |valid;
        span_next.done = valid & done;
        span_next.q    = q_reg;
    end

endmodule

// ===== src/max_pool_argmax_nchw.sv =====
// ----------------------------------------------------------------------------
// max_pool_argmax_nchw
// streaming 2-d max pooling with argmax over nchw raster samples
// ----------------------------------------------------------------------------
// one sample beat enters on s_axis in channel, row, column order; tuser high
// restarts the image position. every pooling window that a sample completes
// leaves as one m_axis beat with tlast on the final one for that sample;
// samples that complete nothing produce no beat.
// running maxima live in one slot ram, read, updated and written back per
// window. a sample first passes the range setup states (div, prep, setup),
// then takes one ram read and one write back per window it touches. a result
// stalls only while the output register is still held by the receiver; the
// next sample is taken as soon as the current one is done. after reset, and
// once every 16 restarts, a clearing pass sweeps all 272 slots of the slot
// ram; during it s_axis_tready stays low.
// configuration writes on cfg_* are always taken and must come while idle.
// ----------------------------------------------------------------------------
module max_pool_argmax_nchw (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    input  logic        s_axis_tuser,   // restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // pooled_value, source_index, channel_id, out_row, out_col
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import mpa_pkg::*;

    cfg_t             cfg;
    span_t            row_span;
    span_t            col_span;
    state_t           state_reg, state_next;
    logic             pend_reg, pend_next;
    logic [GEN_W-1:0] gen_reg, gen_next;
    logic [SLOT_AW-1:0] clr_reg, clr_next;
    logic [5:0]       pc_reg, pc_next, pr_reg, pr_next, pw_reg, pw_next;
    logic [1:0]       ra_reg, ra_next, cb_reg, cb_next;
    logic             m_valid_reg, m_valid_next;
    logic [55:0]      m_data_reg;
    logic             m_last_reg;
    logic [5:0]       cc_reg, cr_reg, cw_reg;
    logic [15:0]      val_reg;
    logic [11:0]      idxa_reg;
    logic [17:0]      idx_reg;
    logic             accept;
    logic             fresh;
    logic [5:0]       cur_c, cur_r, cur_w;
    logic [6:0]       wi, wj;
    logic [SLOT_AW-1:0] slot;
    logic             ram_we, ram_re;
    logic [SLOT_AW-1:0] ram_waddr;
    slot_t            ram_wdata, ram_rdata;
    logic             seen, take, win_done, out_load, out_free;
    logic [15:0]      nmax;
    logic [17:0]      nidx;

    mpa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mpa_span u_row (
        .clk   (clk),
        .start (accept),
        .pos   (cur_r),
        .dim   (cfg.hh),
        .cfg   (cfg),
        .span  (row_span)
    );

    mpa_span u_col (
        .clk   (clk),
        .start (accept),
        .pos   (cur_w),
        .dim   (cfg.ww),
        .cfg   (cfg),
        .span  (col_span)
    );

    mpa_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    assign fresh = s_axis_tuser || (7'(pc_reg) >= cfg.cc) || (7'(pr_reg) >= cfg.hh)
                   || (7'(pw_reg) >= cfg.ww);
    assign cur_c = fresh ? 6'd0 : pc_reg;
    assign cur_r = fresh ? 6'd0 : pr_reg;
    assign cur_w = fresh ? 6'd0 : pw_reg;

    assign wi   = row_span.q - 7'(ra_reg);
    assign wj   = col_span.q - 7'(cb_reg);
    assign slot = SLOT_AW'(wi[1:0]) * SLOT_AW'(SLOT_COLS) + SLOT_AW'(wj);

    // slot update
    always_comb
    begin
        seen     = ram_rdata.seen && (ram_rdata.gen == gen_reg);
        take     = !seen || ($signed(val_reg) > $signed(ram_rdata.max));
        nmax     = take ? val_reg : ram_rdata.max;
        nidx     = take ? idx_reg : ram_rdata.index;
        win_done = row_span.done[ra_reg] && col_span.done[cb_reg];
        out_free = !m_valid_reg || m_axis_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            pend_reg    <= 1'b0;
            gen_reg     <= '0;
            clr_reg     <= '0;
            pc_reg      <= '0;
            pr_reg      <= '0;
            pw_reg      <= '0;
            ra_reg      <= '0;
            cb_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            gen_reg     <= gen_next;
            clr_reg     <= clr_next;
            pc_reg      <= pc_next;
            pr_reg      <= pr_next;
            pw_reg      <= pw_next;
            ra_reg      <= ra_next;
            cb_reg      <= cb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cc_reg  <= cur_c;
            cr_reg  <= cur_r;
            cw_reg  <= cur_w;
            val_reg <= s_axis_tdata;
        end
        if (state_reg == ST_DIV)
        begin
            idxa_reg <= 12'(cc_reg) * 12'(cfg.hh) + 12'(cr_reg);
        end
        if (state_reg == ST_PREP)
        begin
            idx_reg <= 18'(idxa_reg) * 18'(cfg.ww) + 18'(cw_reg);
        end
        if (out_load)
        begin
            m_data_reg <= {2'b00, wj, wi, cc_reg, nidx, nmax};
            m_last_reg <= (ra_reg == row_span.lastdone) && (cb_reg == col_span.lastdone);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        pend_next    = pend_reg;
        gen_next     = gen_reg;
        clr_next     = clr_reg;
        pc_next      = pc_reg;
        pr_next      = pr_reg;
        pw_next      = pw_reg;
        ra_next      = ra_reg;
        cb_next      = cb_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = slot;
        ram_wdata    = '0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == SLOT_AW'(SLOT_COUNT - 1))
                begin
                    clr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_DIV : ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                    if (fresh)
                    begin
                        gen_next = gen_reg + 1'b1;
                        if (gen_next == '0)
                        begin
                            pend_next  = 1'b1;
                            state_next = ST_CLEAR;
                        end
                    end
                    pc_next = cur_c;
                    pr_next = cur_r;
                    pw_next = cur_w + 6'd1;
                    if (7'(cur_w) + 7'd1 >= cfg.ww)
                    begin
                        pw_next = '0;
                        pr_next = cur_r + 6'd1;
                        if (7'(cur_r) + 7'd1 >= cfg.hh)
                        begin
                            pr_next = '0;
                            pc_next = cur_c + 6'd1;
                            if (7'(cur_c) + 7'd1 >= cfg.cc)
                            begin
                                pc_next = '0;
                            end
                        end
                    end
                end
            end
            ST_DIV:
            begin
                state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                ra_next    = row_span.first;
                cb_next    = col_span.first;
                state_next = (row_span.any && col_span.any) ? ST_RD : ST_IDLE;
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (!win_done || out_free)
                begin
                    ram_we = 1'b1;
                    if (win_done)
                    begin
                        out_load       = 1'b1;
                        m_valid_next   = 1'b1;
                        ram_wdata.gen  = gen_reg;
                        ram_wdata.seen = 1'b0;
                    end
                    else
                    begin
                        ram_wdata.gen   = gen_reg;
                        ram_wdata.seen  = 1'b1;
                        ram_wdata.index = nidx;
                        ram_wdata.max   = nmax;
                    end
                    state_next = ST_RD;
                    if (cb_reg == col_span.last)
                    begin
                        cb_next = col_span.first;
                        if (ra_reg == row_span.last)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            ra_next = ra_reg - 2'd1;
                        end
                    end
                    else
                    begin
                        cb_next = cb_reg - 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WR || state_reg == ST_CLEAR))
        else $error("slot ram written outside update or clearing");

    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_valid_reg || m_axis_tready))
        else $error("result register overwritten while held");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIV || state_reg == ST_CLEAR))
        else $error("sample accepted without starting work");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (ra_reg <= row_span.first && ra_reg >= row_span.last))
        else $error("window row counter out of range");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR) |-> (cb_reg <= col_span.first && cb_reg >= col_span.last))
        else $error("window column counter out of range");

endmodule
